FILE: sv/ssbm_pkg.sv
// ----------------------------------------------------------------------------
// ssbm_pkg: shared types and constants of the SSB/AM I-Q modulator
// Tap coefficients of the low-pass and Hilbert sections, arithmetic widths,
// sideband mode codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ssbm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int NTAPS       = 15;
  localparam int W_X         = 12;
  localparam int W_COEF      = 13;
  localparam int W_SUM       = 25;
  localparam int W_ACC       = 20;
  localparam int W_QH        = 13;
  localparam int W_CODE      = 12;
  localparam int W_RANGE     = 13;
  localparam int W_OUT       = 14;
  localparam int SEXT_SHIFT  = W_X - SAMPLE_BITS;

  typedef logic signed [W_COEF-1:0] coef_arr_t [NTAPS];

  // Coefficients ordered by sample age, newest first
  localparam coef_arr_t LP_COEFS = '{
    13'sd3, 13'sd4, -13'sd3, -13'sd14, -13'sd15, 13'sd6, 13'sd38, 13'sd53,
    13'sd38, 13'sd6, -13'sd15, -13'sd14, -13'sd3, 13'sd4, 13'sd3
  };

  localparam coef_arr_t HB_COEFS = '{
    -13'sd315, 13'sd0, -13'sd440, 13'sd0, -13'sd734, 13'sd0, -13'sd2202, 13'sd0,
    13'sd2202, 13'sd0, 13'sd734, 13'sd0, 13'sd440, 13'sd0, 13'sd315
  };

  typedef enum logic [1:0] {
    SB_UPPER = 2'd0,
    SB_LOWER = 2'd1,
    SB_AM    = 2'd2
  } sideband_t;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BIAS  = 2'd1;
  localparam logic [1:0] REG_RANGE = 2'd2;

  localparam logic [1:0]         MODE_RESET  = 2'd0;
  localparam logic [W_CODE-1:0]  BIAS_RESET  = 12'd128;
  localparam logic [W_RANGE-1:0] RANGE_RESET = 13'd256;

  function automatic logic signed [W_X-1:0] sext_sample(input logic [W_X-1:0] v);
    return $signed(v << SEXT_SHIFT) >>> SEXT_SHIFT;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ssbm_tap_cell.sv
// ----------------------------------------------------------------------------
// ssbm_tap_cell: one cell of a transposed FIR chain
// Holds one partial sum; adds its tap product and hands it to the neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbm_tap_cell
  import ssbm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic signed [W_X-1:0]    sample,
  input  wire logic signed [W_COEF-1:0] coef,
  input  wire logic signed [W_SUM-1:0]  sum_in,
  output      logic signed [W_SUM-1:0]  sum_out
);

  logic signed [W_SUM-1:0] prod;

  assign prod = W_SUM'(sample) * W_SUM'(coef);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= '0;
    end else if (en) begin
      sum_out <= sum_in + prod;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssbm_tap_chain.sv
// ----------------------------------------------------------------------------
// ssbm_tap_chain: transposed-form FIR as a row of tap cells
// Each beat advances every cell; the sum covers the new sample and history.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbm_tap_chain
  import ssbm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic signed [W_X-1:0]   sample,
  input  wire coef_arr_t               coefs,
  output      logic signed [W_SUM-1:0] sum
);

  logic signed [W_SUM-1:0] part [1:NTAPS];
  logic signed [W_SUM-1:0] lead;

  assign part[NTAPS] = '0;

  for (genvar j = 1; j < NTAPS; j++) begin : g_cell
    ssbm_tap_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .sample  (sample),
      .coef    (coefs[j]),
      .sum_in  (part[j+1]),
      .sum_out (part[j])
    );
  end

  assign lead = W_SUM'(sample) * W_SUM'(coefs[0]);
  assign sum  = lead + part[1];

endmodule

`default_nettype wire

FILE: sv/ssb_am_iq_modulator.sv
// ----------------------------------------------------------------------------
// ssb_am_iq_modulator: SSB/AM I-Q modulator, transmit path
// Pipeline: an accepted sample beat is registered in acc1, f2, qsum3, qh4
// and i_out/q_out in turn. Throughput: one beat per cycle unless result_ready
// stalls the flow; the two tap chains advance once per beat.
// Reset: delay lines and pipeline clear; mode USB, bias 128, range 256.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_am_iq_modulator
  import ssbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  input  wire logic              sample_valid,
  output      logic              sample_ready,
  input  wire logic [W_X-1:0]    audio_sample,
  output      logic              result_valid,
  input  wire logic              result_ready,
  output      logic [W_CODE-1:0] i_out,
  output      logic [W_CODE-1:0] q_out
);

  logic [1:0]         sideband_mode;
  logic [W_CODE-1:0]  bias_level;
  logic [W_RANGE-1:0] code_range;
  logic               wr_en;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic take1, take2, take3, take4, take5;

  logic signed [W_ACC-1:0]  acc1;
  logic signed [W_X-1:0]    f2;
  logic signed [W_SUM-1:0]  qsum3;
  logic signed [W_X-1:0]    centre3;
  logic signed [W_QH-1:0]   qh4;
  logic signed [W_X-1:0]    c4;
  logic signed [W_X-1:0]    fl [7];

  logic signed [W_SUM-1:0]  lp_sum;
  logic signed [W_SUM-1:0]  hb_sum;
  logic signed [W_X-1:0]    sample_s;

  logic signed [W_ACC-1:0]  acc_adj;
  logic signed [W_SUM-1:0]  qsum_adj;
  logic signed [W_QH-1:0]   qdiv;
  logic signed [W_QH-1:0]   qh_next;
  logic signed [W_X-1:0]    c_adj;
  logic signed [W_X-1:0]    c8;
  logic signed [W_QH-1:0]   qh_adj;
  logic signed [W_QH-1:0]   qh8;
  logic signed [W_OUT-1:0]  bias_s;
  logic signed [W_OUT-1:0]  ival;
  logic signed [W_OUT-1:0]  qval;
  logic [W_CODE-1:0]        code_top;

  // Configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sideband_mode <= MODE_RESET;
      bias_level    <= BIAS_RESET;
      code_range    <= RANGE_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MODE:  sideband_mode <= pwdata[1:0];
        REG_BIAS:  bias_level    <= pwdata[W_CODE-1:0];
        REG_RANGE: code_range    <= pwdata[W_RANGE-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {30'd0, sideband_mode};
      REG_BIAS:  prdata = {20'd0, bias_level};
      REG_RANGE: prdata = {19'd0, code_range};
      default:   prdata = '0;
    endcase
  end

  // Pipeline flow
  assign rdy_out      = !result_valid || result_ready;
  assign rdy4         = !v4 || rdy_out;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign sample_ready = rdy1;

  assign take1 = sample_valid && rdy1;
  assign take2 = v1 && rdy2;
  assign take3 = v2 && rdy3;
  assign take4 = v3 && rdy4;
  assign take5 = v4 && rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1)    v1           <= sample_valid;
      if (rdy2)    v2           <= v1;
      if (rdy3)    v3           <= v2;
      if (rdy4)    v4           <= v3;
      if (rdy_out) result_valid <= v4;
    end
  end

  // Low-pass section
  assign sample_s = sext_sample(audio_sample);

  ssbm_tap_chain u_lp_chain (
    .clk    (clk),
    .rst    (rst),
    .en     (take1),
    .sample (sample_s),
    .coefs  (LP_COEFS),
    .sum    (lp_sum)
  );

  assign acc_adj = (acc1 < 0) ? acc1 + W_ACC'(255) : acc1;

  // Hilbert section
  ssbm_tap_chain u_hb_chain (
    .clk    (clk),
    .rst    (rst),
    .en     (take3),
    .sample (f2),
    .coefs  (HB_COEFS),
    .sum    (hb_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 7; k++) fl[k] <= '0;
    end else if (take3) begin
      fl[0] <= f2;
      for (int k = 1; k < 7; k++) fl[k] <= fl[k-1];
    end
  end

  assign qsum_adj = (qsum3 < 0) ? qsum3 + W_SUM'(4095) : qsum3;
  assign qdiv     = qsum_adj[W_SUM-1:12];

  always_comb begin
    case (sideband_mode)
      SB_UPPER: qh_next = -qdiv;
      SB_LOWER: qh_next = qdiv;
      SB_AM:    qh_next = W_QH'(centre3);
      default:  qh_next = '0;
    endcase
  end

  // Output scaling and clipping
  assign c_adj  = (c4 < 0) ? c4 + W_X'(7) : c4;
  assign c8     = c_adj >>> 3;
  assign qh_adj = (qh4 < 0) ? qh4 + W_QH'(7) : qh4;
  assign qh8    = qh_adj >>> 3;
  assign bias_s = $signed({2'b00, bias_level});
  assign ival   = bias_s + W_OUT'(c8);
  assign qval   = bias_s - W_OUT'(qh8);

  always_comb begin
    if (code_range == '0) begin
      code_top = '0;
    end else if (code_range > W_RANGE'(4096)) begin
      code_top = '1;
    end else begin
      code_top = W_CODE'(code_range - W_RANGE'(1));
    end
  end

  function automatic logic [W_CODE-1:0] clip_code(input logic signed [W_OUT-1:0] v,
                                                  input logic [W_CODE-1:0] top);
    logic [W_CODE-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, top})) begin
      r = top;
    end else begin
      r = v[W_CODE-1:0];
    end
    return r;
  endfunction

  // Stage payloads
  always_ff @(posedge clk) begin
    if (take1) acc1 <= lp_sum[W_ACC-1:0];
    if (take2) f2   <= acc_adj[W_ACC-1:8];
    if (take3) begin
      qsum3   <= hb_sum;
      centre3 <= fl[6];
    end
    if (take4) begin
      qh4 <= qh_next;
      c4  <= centre3;
    end
    if (take5) begin
      i_out <= clip_code(ival, code_top);
      q_out <= clip_code(qval, code_top);
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    take1 |=> v1)
    else $error("accepted beat missing from first stage");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(acc1))
    else $error("stalled first stage lost its beat");

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(qsum3))
    else $error("stalled Hilbert stage lost its beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !v1 && !v3)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: sim/ssb_am_iq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssb_am_iq_checker: result checker for the SSB/AM I-Q modulator
// Snoops the APB register writes and both beat channels. It keeps a shadow
// copy of the two tap lines and the registers, predicts the I/Q DAC codes of
// every accepted sample and matches them in order against the result beats.
// ----------------------------------------------------------------------------
module ssb_am_iq_checker
  import ssbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              sample_valid,
  input  logic              sample_ready,
  input  logic [W_X-1:0]    audio_sample,
  input  logic              result_valid,
  input  logic              result_ready,
  input  logic [W_CODE-1:0] i_out,
  input  logic [W_CODE-1:0] q_out,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [W_X-1:0]    smp;
    logic [W_CODE-1:0] i_code;
    logic [W_CODE-1:0] q_code;
  } dac_pair_t;

  logic signed [W_X-1:0] audio_taps   [NTAPS];
  logic signed [W_X-1:0] lowpass_taps [NTAPS];
  logic [1:0]            mode_reg;
  logic [W_CODE-1:0]     bias_reg;
  logic [W_RANGE-1:0]    range_reg;
  dac_pair_t             dac_codes_due [$];

  function automatic logic [W_CODE-1:0] dac_clip(input int v);
    int top;
    top = int'(range_reg) - 1;
    if (top < 0) top = 0;
    if (top > (1 << W_CODE) - 1) top = (1 << W_CODE) - 1;
    if (v < 0) return '0;
    if (v > top) return W_CODE'(top);
    return W_CODE'(v);
  endfunction

  function automatic dac_pair_t modulate(input logic [W_X-1:0] smp);
    int        k;
    int        lp_sum;
    int        quad_sum;
    int        quad;
    int        centre;
    dac_pair_t r;
    for (k = 0; k < NTAPS - 1; k++) audio_taps[k] = audio_taps[k + 1];
    audio_taps[NTAPS - 1] = sext_sample(smp);
    lp_sum = 3 * (audio_taps[0] + audio_taps[14]) + 4 * (audio_taps[1] + audio_taps[13])
           - 3 * (audio_taps[2] + audio_taps[12]) - 14 * (audio_taps[3] + audio_taps[11])
           - 15 * (audio_taps[4] + audio_taps[10]) + 6 * (audio_taps[5] + audio_taps[9])
           + 38 * (audio_taps[6] + audio_taps[8]) + 53 * audio_taps[7];
    for (k = 0; k < NTAPS - 1; k++) lowpass_taps[k] = lowpass_taps[k + 1];
    lowpass_taps[NTAPS - 1] = W_X'(lp_sum / 256);
    quad_sum = 315 * (lowpass_taps[0] - lowpass_taps[14])
             + 440 * (lowpass_taps[2] - lowpass_taps[12])
             + 734 * (lowpass_taps[4] - lowpass_taps[10])
             + 2202 * (lowpass_taps[6] - lowpass_taps[8]);
    centre = lowpass_taps[7];
    case (mode_reg)
      SB_UPPER: quad = -(quad_sum / 4096);
      SB_LOWER: quad = quad_sum / 4096;
      SB_AM:    quad = centre;
      default:  quad = 0;
    endcase
    r.smp    = smp;
    r.i_code = dac_clip(int'(bias_reg) + centre / 8);
    r.q_code = dac_clip(int'(bias_reg) - quad / 8);
    return r;
  endfunction

  task automatic flag_fault(input string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    dac_pair_t want;
    if (rst) begin
      for (int k = 0; k < NTAPS; k++) begin
        audio_taps[k]   = '0;
        lowpass_taps[k] = '0;
      end
      mode_reg  = MODE_RESET;
      bias_reg  = BIAS_RESET;
      range_reg = RANGE_RESET;
      dac_codes_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:  mode_reg  = pwdata[1:0];
          REG_BIAS:  bias_reg  = pwdata[W_CODE-1:0];
          REG_RANGE: range_reg = pwdata[W_RANGE-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (dac_codes_due.size() == 0) begin
          flag_fault($sformatf("result beat with nothing outstanding: i=%0d q=%0d",
                               i_out, q_out));
        end else begin
          want = dac_codes_due.pop_front();
          if (i_out !== want.i_code || q_out !== want.q_code)
            flag_fault($sformatf("mismatch for sample %h: expected i=%0d q=%0d, got i=%0d q=%0d",
                                 want.smp, want.i_code, want.q_code, i_out, q_out));
        end
      end
      if (sample_valid && sample_ready) dac_codes_due.push_back(modulate(audio_sample));
    end
    pending = dac_codes_due.size();
  end

endmodule

FILE: sim/tb_ssb_am_iq_modulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ssb_am_iq_modulator: testbench for the SSB/AM I-Q modulator
// Runs a short directed burst of extreme and step samples at the reset
// settings, then phases of random audio under changing sideband, bias and
// range settings, including the unused mode, zero and oversized ranges and
// a write to an unmapped register. Both channels idle at random; one phase
// runs without gaps and one holds the result side off long enough to stall
// the sample input. Checking is done by ssb_am_iq_checker.
// ----------------------------------------------------------------------------
module tb_ssb_am_iq_modulator;
  import ssbm_pkg::*;

  localparam logic [1:0] REG_VOID   = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         PHASES     = 13;
  localparam int         BURST      = 64;

  localparam logic [0:24][W_X-1:0] DIRECTED = {
    12'h000, 12'h7FF, 12'h800, 12'h001, 12'hFFF,
    12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF,
    12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800,
    12'h555, 12'hAAA, 12'h7FF, 12'h800
  };

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [3:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  logic [W_X-1:0]    audio_sample = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [W_CODE-1:0] i_out;
  logic [W_CODE-1:0] q_out;
  int                errors;
  int                pending;
  bit                calm         = 1'b0;
  bit                choke_req    = 1'b0;

  always #6 clk = ~clk;

  ssb_am_iq_modulator u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .audio_sample (audio_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .i_out        (i_out),
    .q_out        (q_out)
  );

  ssb_am_iq_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .audio_sample (audio_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .i_out        (i_out),
    .q_out        (q_out),
    .errors       (errors),
    .pending      (pending)
  );

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [W_X-1:0] smp);
    while (!calm && $urandom_range(99) < 16) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    audio_sample = smp;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : drain
    int hold;
    bit choke_done;
    hold       = 0;
    choke_done = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        hold       = 300;
      end
      if (hold > 0) begin
        result_ready = 1'b0;
        hold--;
      end else begin
        result_ready = calm || $urandom_range(99) >= 16;
      end
    end
  end

  initial begin : stimulus
    logic [W_X-1:0] smp;
    logic [31:0]    mode_w;
    logic [31:0]    bias_w;
    logic [31:0]    range_w;
    smp = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < 25; k++) send_sample(DIRECTED[k]);
    sample_valid = 1'b0;

    for (int ph = 1; ph <= PHASES; ph++) begin
      // drain the pipeline before touching the registers
      while (pending != 0) @(negedge clk);
      repeat (8) @(negedge clk);
      case (ph)
        1: begin mode_w = SB_LOWER;   bias_w = 2048; range_w = 4096; end
        2: begin mode_w = SB_AM;      bias_w = 2048; range_w = 4096; end
        3: begin mode_w = MODE_SPARE; bias_w = 4095; range_w = 0;    end
        4: begin mode_w = SB_UPPER;   bias_w = 0;    range_w = 1;    end
        5: begin mode_w = SB_UPPER;   bias_w = 2048; range_w = 8191; end
        6: begin mode_w = SB_LOWER;   bias_w = 1000; range_w = 4097; end
        7: begin mode_w = SB_AM;      bias_w = 4095; range_w = 4096; end
        default: begin
          mode_w = $urandom;
          bias_w = $urandom;
          if ($urandom_range(1))
            range_w = ($urandom & 32'hFFFF_E000) | $urandom_range(3000, 5000);
          else
            range_w = $urandom;
        end
      endcase
      apb_write(REG_MODE, mode_w);
      apb_write(REG_BIAS, bias_w);
      apb_write(REG_RANGE, range_w);
      apb_write(REG_VOID, $urandom);
      calm = (ph == 5);

      for (int n = 0; n < BURST; n++) begin
        if (ph == 9 && n == 20) choke_req = 1'b1;
        case ($urandom_range(9))
          0, 1, 2, 3: smp = $urandom;
          4, 5:       smp = W_X'($urandom_range(128) - 64);
          6:          smp = $urandom_range(1) ? 12'h7FF : 12'h800;
          9:          smp = ~smp;
          default:    ;
        endcase
        send_sample(smp);
      end
      sample_valid = 1'b0;
      calm         = 1'b0;
    end

    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
